### src/itma_pkg.sv
// ----------------------------------------------------------------------------
// itma_pkg
// Shared types and constants for the int8 tile matmul accumulate block.
// ----------------------------------------------------------------------------
package itma_pkg;

  localparam int TILE_ROWS_DEF = 4;
  localparam int TILE_COLS_DEF = 4;
  localparam int LANES         = 4;   // operand byte lanes on the input port
  localparam int IDX_W         = 2;   // width of the row/col index fields
  localparam int OPND_W        = 8;
  localparam int PROD_W        = 16;
  localparam int ACC_W         = 32;

  typedef logic signed [OPND_W-1:0] opnd_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // Per-cycle control broadcast to every cell.
  typedef struct packed {
    logic acc_en;   // a step transfer happens this cycle
    logic clear;    // zero the accumulator before the add
    logic load;     // copy post-add sums into the drain chain
    logic shift;    // drain chain moves one place toward the head
  } cell_ctrl_t;

endpackage

### src/itma_mac_cell.sv
// ----------------------------------------------------------------------------
// itma_mac_cell
// One MAC cell: 32-bit accumulator plus one slot of the result drain chain.
// ----------------------------------------------------------------------------
module itma_mac_cell
  import itma_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  opnd_t      a,
  input  opnd_t      b,
  input  acc_t       chain_in,    // drain slot of the next cell
  output acc_t       chain_out    // this cell's drain slot
);

  logic signed [PROD_W-1:0] prod;
  acc_t acc_r, acc_nxt, sum;
  acc_t drain_r, drain_nxt;

  always_comb begin
    prod = a * b;
    sum  = (ctrl.clear ? '0 : acc_r) + ACC_W'(prod);
    acc_nxt = ctrl.acc_en ? sum : acc_r;
    if (ctrl.load) begin
      drain_nxt = sum;
    end else if (ctrl.shift) begin
      drain_nxt = chain_in;
    end else begin
      drain_nxt = drain_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    drain_r <= drain_nxt;
  end

  assign chain_out = drain_r;

endmodule

### src/itma_drain_ctrl.sv
// ----------------------------------------------------------------------------
// itma_drain_ctrl
// Handshake and drain sequencing: fill count and row/col tags of the output.
// ----------------------------------------------------------------------------
module itma_drain_ctrl
  import itma_pkg::*;
#(
  parameter int TILE_ROWS = TILE_ROWS_DEF,
  parameter int TILE_COLS = TILE_COLS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_first_step,
  input  logic             in_last_step,
  output logic             in_ready,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [IDX_W-1:0] out_row,
  output logic [IDX_W-1:0] out_col,
  output logic             out_last_result,
  output cell_ctrl_t       ctrl
);

  localparam int CELLS = TILE_ROWS * TILE_COLS;
  localparam int CNT_W = $clog2(CELLS + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] row_r, row_nxt, col_r, col_nxt;
  logic             pop, drain_free, step_xfer;

  always_comb begin
    out_valid       = (cnt_r != '0);
    out_last_result = (cnt_r == CNT_W'(1));
    pop             = out_valid && out_ready;
    drain_free      = (cnt_r == '0) || (out_last_result && out_ready);
    in_ready        = !in_last_step || drain_free;
    step_xfer       = in_valid && in_ready;

    ctrl.acc_en = step_xfer;
    ctrl.clear  = in_first_step;
    ctrl.load   = step_xfer && in_last_step;
    ctrl.shift  = pop;

    cnt_nxt = cnt_r;
    row_nxt = row_r;
    col_nxt = col_r;
    if (ctrl.load) begin
      cnt_nxt = CNT_W'(CELLS);
      row_nxt = '0;
      col_nxt = '0;
    end else if (pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      if (col_r == IDX_W'(TILE_COLS - 1)) begin
        col_nxt = '0;
        row_nxt = row_r + IDX_W'(1);
      end else begin
        col_nxt = col_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      row_r <= '0;
      col_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  assign out_row = row_r;
  assign out_col = col_r;

endmodule

### src/int8_tile_matmul_accumulate.sv
// ----------------------------------------------------------------------------
// int8_tile_matmul_accumulate
// Output-stationary TILE_ROWS x TILE_COLS grid of signed 8-bit MAC cells.
// ----------------------------------------------------------------------------
// Each input transfer is one K step: one A byte per tile row, one B byte per
// tile column. Every cell (i,j) adds a_i*b_j to its own 32-bit accumulator in
// the cycle of the transfer (wrapping modulo 2^32); first_step zeroes the
// accumulators ahead of that add. A step with last_step copies the post-add
// sums into a drain chain that runs through all cells in row-major order and
// shifts one place toward the head per output transfer, so the tile's sums
// come out as TILE_ROWS*TILE_COLS transfers (16 by default) tagged with row,
// column and a last marker on the final one. Accumulators keep their values
// after the copy. Steps are taken one per cycle, also while the chain drains;
// only a step that carries last_step waits until the chain is empty or its
// final sum leaves in that same cycle. Bytes on lanes at or above TILE_ROWS /
// TILE_COLS are ignored. Reset clears all accumulators at once.
// ----------------------------------------------------------------------------
module int8_tile_matmul_accumulate
  import itma_pkg::*;
#(
  parameter int TILE_ROWS = TILE_ROWS_DEF,
  parameter int TILE_COLS = TILE_COLS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // step input
  input  logic              in_valid,
  output logic              in_ready,
  input  logic signed [7:0] in_a_row0,
  input  logic signed [7:0] in_a_row1,
  input  logic signed [7:0] in_a_row2,
  input  logic signed [7:0] in_a_row3,
  input  logic signed [7:0] in_b_row0,
  input  logic signed [7:0] in_b_row1,
  input  logic signed [7:0] in_b_row2,
  input  logic signed [7:0] in_b_row3,
  input  logic              in_first_step,
  input  logic              in_last_step,
  // sum output
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_row,
  output logic [1:0]        out_col,
  output logic signed [31:0] out_sum_value,
  output logic              out_last_result
);

  localparam int CELLS = TILE_ROWS * TILE_COLS;

  cell_ctrl_t ctrl;
  opnd_t      a_lane [LANES];
  opnd_t      b_lane [LANES];
  acc_t       chain  [CELLS+1];   // chain[k] = drain slot of cell k, tail is 0

  assign a_lane[0] = in_a_row0;
  assign a_lane[1] = in_a_row1;
  assign a_lane[2] = in_a_row2;
  assign a_lane[3] = in_a_row3;
  assign b_lane[0] = in_b_row0;
  assign b_lane[1] = in_b_row1;
  assign b_lane[2] = in_b_row2;
  assign b_lane[3] = in_b_row3;

  // handshake, fill count, output tags
  itma_drain_ctrl #(
    .TILE_ROWS (TILE_ROWS),
    .TILE_COLS (TILE_COLS)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_first_step   (in_first_step),
    .in_last_step    (in_last_step),
    .in_ready        (in_ready),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_last_result (out_last_result),
    .ctrl            (ctrl)
  );

  // cell grid; drain chain links cell k to cell k+1 in row-major order
  assign chain[CELLS] = '0;

  for (genvar i = 0; i < TILE_ROWS; i++) begin : g_row
    for (genvar j = 0; j < TILE_COLS; j++) begin : g_col
      itma_mac_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .a         (a_lane[i]),
        .b         (b_lane[j]),
        .chain_in  (chain[i*TILE_COLS + j + 1]),
        .chain_out (chain[i*TILE_COLS + j])
      );
    end
  end

  // head of the chain is the sum on offer
  assign out_sum_value = chain[0];

endmodule

### bench/int8_tile_matmul_accumulate_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int8_tile_matmul_accumulate_tb
// Self-checking bench for the 4x4 int8 multiply-accumulate tile.
// ----------------------------------------------------------------------------
// Steps are streamed on the input channel, and a scoreboard model of the
// sixteen accumulators predicts every sum that a last step drains. Each drained
// transfer is checked against the oldest predicted sum, field by field.
// Directed tests cover one-step tiles at the operand extremes, carry-over
// across emissions and a long tile built from the largest products. Random
// tiles follow, with idle cycles on the sender, stalls on the receiver and a
// stretch with neither.
// ----------------------------------------------------------------------------
module int8_tile_matmul_accumulate_tb;
  import itma_pkg::*;

  localparam int CELLS       = TILE_ROWS_DEF * TILE_COLS_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_SLACK = 40;       // cycles allowed past the last sum
  localparam int RANDOM_STEPS = 270;
  // K length of the long tile at the largest products.
  localparam int LONG_STEPS  = 40;

  // One K step as it crosses the input channel.
  typedef struct packed {
    opnd_t [LANES-1:0] a;
    opnd_t [LANES-1:0] b;
    logic              first;
    logic              last;
  } step_t;

  // One drained sum.
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    acc_t             sum;
    logic             last;
  } tile_sum_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  opnd_t      in_a_row0 = '0;
  opnd_t      in_a_row1 = '0;
  opnd_t      in_a_row2 = '0;
  opnd_t      in_a_row3 = '0;
  opnd_t      in_b_row0 = '0;
  opnd_t      in_b_row1 = '0;
  opnd_t      in_b_row2 = '0;
  opnd_t      in_b_row3 = '0;
  logic       in_first_step = 1'b0;
  logic       in_last_step = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_row;
  logic [1:0] out_col;
  acc_t       out_sum_value;
  logic       out_last_result;

  // Scoreboard state: mirror of the accumulators and the sums still due.
  acc_t      acc_mirror [CELLS];
  tile_sum_t sums_due [$];

  // Traffic shaping knobs, flipped by the tests.
  bit feed_gaps   = 1'b1;
  bit sink_stalls = 1'b1;

  int unsigned cycle_count  = 0;
  int unsigned steps_sent   = 0;
  int unsigned tiles_sent   = 0;
  int unsigned sums_checked = 0;
  int unsigned fail_count   = 0;

  int8_tile_matmul_accumulate i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_a_row0       (in_a_row0),
    .in_a_row1       (in_a_row1),
    .in_a_row2       (in_a_row2),
    .in_a_row3       (in_a_row3),
    .in_b_row0       (in_b_row0),
    .in_b_row1       (in_b_row1),
    .in_b_row2       (in_b_row2),
    .in_b_row3       (in_b_row3),
    .in_first_step   (in_first_step),
    .in_last_step    (in_last_step),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_sum_value   (out_sum_value),
    .out_last_result (out_last_result)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Receiver: ready drops in about a third of the cycles while stalls are on.
  always @(posedge clk) begin
    out_ready <= sink_stalls ? ($urandom_range(99) >= 32) : 1'b1;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Cycle limit reached with %0d sums still due", sums_due.size());
    $display("== FAIL ==");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Scoreboard model: apply one accepted step to the mirror. A first step
  // zeroes each cell before its add; a last step queues all sixteen post-add
  // sums in row-major order, the final one carrying the last marker. The
  // mirror keeps its values after an emission.
  // --------------------------------------------------------------------------
  task automatic accumulate_step(input step_t s);
    int        ai;
    int        bj;
    int        idx;
    tile_sum_t ts;
    for (int i = 0; i < TILE_ROWS_DEF; i++) begin
      for (int j = 0; j < TILE_COLS_DEF; j++) begin
        idx = i * TILE_COLS_DEF + j;
        ai  = $signed(s.a[i]);
        bj  = $signed(s.b[j]);
        if (s.first) begin
          acc_mirror[idx] = '0;
        end
        acc_mirror[idx] = acc_mirror[idx] + acc_t'(ai * bj);   // wraps mod 2^32
      end
    end
    if (s.last) begin
      for (int n = 0; n < CELLS; n++) begin
        ts.row  = IDX_W'(n / TILE_COLS_DEF);
        ts.col  = IDX_W'(n % TILE_COLS_DEF);
        ts.sum  = acc_mirror[n];
        ts.last = (n == CELLS - 1);
        sums_due.push_back(ts);
      end
      tiles_sent++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checker. Outputs and ready are sampled at the edge itself, so the
  // values seen are the ones the transfer was made with.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    tile_sum_t want;
    if (rst_n && out_valid && out_ready) begin
      sums_checked <= sums_checked + 1;
      if (sums_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("%0t: unexpected sum transfer row %0d col %0d value %0d",
                   $realtime, out_row, out_col, out_sum_value);
        end
      end else begin
        want = sums_due.pop_front();
        if (out_row !== want.row || out_col !== want.col ||
            out_sum_value !== want.sum || out_last_result !== want.last) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: sum mismatch, expected row %0d col %0d value %0d last %0b",
                     $realtime, want.row, want.col, want.sum, want.last);
            $display("%0t:                 actual row %0d col %0d value %0d last %0b",
                     $realtime, out_row, out_col, out_sum_value, out_last_result);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender. Entered right after a rising edge. Optional idle cycles first,
  // then the step is held until its transfer; valid is left high so that a
  // back-to-back step never sees valid drop within one time step.
  // --------------------------------------------------------------------------
  task automatic send_step(input step_t s);
    if (feed_gaps) begin
      while ($urandom_range(99) < 32) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid      <= 1'b1;
    in_a_row0     <= s.a[0];
    in_a_row1     <= s.a[1];
    in_a_row2     <= s.a[2];
    in_a_row3     <= s.a[3];
    in_b_row0     <= s.b[0];
    in_b_row1     <= s.b[1];
    in_b_row2     <= s.b[2];
    in_b_row3     <= s.b[3];
    in_first_step <= s.first;
    in_last_step  <= s.last;
    do @(posedge clk); while (!in_ready);
    steps_sent++;
    accumulate_step(s);
  endtask

  // Drop valid and hold off until every predicted sum has drained.
  task automatic hold_for_sums();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sums_due.size() != 0) @(posedge clk);
  endtask

  // Operand byte biased toward the corners of the signed range.
  function automatic opnd_t pick_byte();
    case ($urandom_range(7))
      0:       return opnd_t'(-128);
      1:       return opnd_t'(127);
      2:       return opnd_t'(0);
      3:       return opnd_t'(-1);
      default: return opnd_t'($urandom);
    endcase
  endfunction

  function automatic step_t make_step(input logic first, input logic last);
    step_t s;
    for (int l = 0; l < LANES; l++) begin
      s.a[l] = pick_byte();
      s.b[l] = pick_byte();
    end
    s.first = first;
    s.last  = last;
    return s;
  endfunction

  function automatic step_t fill_step(input opnd_t a, input opnd_t b,
                                      input logic first, input logic last);
    step_t s;
    for (int l = 0; l < LANES; l++) begin
      s.a[l] = a;
      s.b[l] = b;
    end
    s.first = first;
    s.last  = last;
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Clear, add and emit in one step, across the operand extremes.
  task automatic test_single_step_tiles();
    step_t s;
    send_step(fill_step(opnd_t'(-128), opnd_t'(-128), 1'b1, 1'b1));
    send_step(fill_step(opnd_t'(127), opnd_t'(127), 1'b1, 1'b1));
    send_step(fill_step(opnd_t'(-128), opnd_t'(127), 1'b1, 1'b1));
    send_step(fill_step(opnd_t'(0), opnd_t'(0), 1'b1, 1'b1));
    send_step(fill_step(opnd_t'(-1), opnd_t'(-1), 1'b1, 1'b1));
    // distinct lanes so a row/column swap shows up
    s.a   = {opnd_t'(4), opnd_t'(-3), opnd_t'(2), opnd_t'(1)};
    s.b   = {opnd_t'(-128), opnd_t'(127), opnd_t'(-7), opnd_t'(5)};
    s.first = 1'b1;
    s.last  = 1'b1;
    send_step(s);
    send_step(make_step(1'b1, 1'b1));
  endtask

  // Steps with no flags, last without first, and adding on after emission.
  task automatic test_carry_over();
    send_step(make_step(1'b0, 1'b0));   // adds onto what the last tile left
    send_step(make_step(1'b1, 1'b0));
    send_step(make_step(1'b0, 1'b0));
    send_step(make_step(1'b0, 1'b1));
    send_step(make_step(1'b0, 1'b0));   // keeps accumulating after the drain
    send_step(make_step(1'b0, 1'b1));
    send_step(make_step(1'b0, 1'b1));   // emit twice in a row
    hold_for_sums();
  endtask

  // Long tile at the largest products. A rows are all -128; B alternates
  // -128 and 127, so half the cells climb by 16384 per step and half fall by
  // 16256. The sender runs without idling.
  task automatic test_long_tile();
    step_t s;
    feed_gaps = 1'b0;
    s = fill_step(opnd_t'(-128), opnd_t'(-128), 1'b1, 1'b0);
    s.b = {opnd_t'(127), opnd_t'(-128), opnd_t'(127), opnd_t'(-128)};
    send_step(s);
    s.first = 1'b0;
    for (int k = 1; k < LONG_STEPS - 1; k++) begin
      send_step(s);
    end
    s.last = 1'b1;
    send_step(s);
    feed_gaps = 1'b1;
  endtask

  // Random tiles: mostly well-formed (first on the opening step, last on the
  // closing one) with short K, now and then a long one, and some stray flags.
  task automatic test_random_tiles();
    int unsigned start;
    int unsigned tile_no;
    int          k_len;
    logic        first;
    logic        last;
    start   = steps_sent;
    tile_no = 0;
    while (steps_sent - start < RANDOM_STEPS) begin
      // a quiet stretch: no idle cycles and no stalls on either side
      feed_gaps   = !(tile_no >= 12 && tile_no < 20);
      sink_stalls = feed_gaps;
      if (tile_no == 25) begin
        hold_for_sums();
      end
      k_len = ($urandom_range(9) == 0) ? int'($urandom_range(17, 40))
                                       : int'($urandom_range(1, 8));
      for (int n = 0; n < k_len; n++) begin
        first = (n == 0);
        last  = (n == k_len - 1);
        if ($urandom_range(9) == 0) begin
          first = 1'($urandom_range(1));
          last  = 1'($urandom_range(1));
        end
        send_step(make_step(first, last));
      end
      tile_no++;
    end
    feed_gaps   = 1'b1;
    sink_stalls = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int n = 0; n < CELLS; n++) begin
      acc_mirror[n] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_step_tiles();
    test_carry_over();
    test_long_tile();
    test_random_tiles();

    // let the last tile drain, then watch for strays
    in_valid <= 1'b0;
    @(posedge clk);
    while (sums_due.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);

    $display("Sent %0d K steps forming %0d tiles; %0d sums drained and checked",
             steps_sent, tiles_sent, sums_checked);
    $display("Included one-step tiles, carry-over, a long tile and %0d failures",
             fail_count);
    if (fail_count == 0 && sums_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
